@@ src/mi3_pkg.sv @@
// mi3_pkg: shared constants and index helpers for the 3x3 matrix inverse.
// No dependencies.
`timescale 1ns / 1ps

package mi3_pkg;

  // Fractional bits: input Q.8, output Q.16; numerator shift = 8 + 16.
  localparam int IN_FRAC    = 8;
  localparam int OUT_FRAC   = 16;
  localparam int FRAC_SHIFT = IN_FRAC + OUT_FRAC;

  // Matrix dimension and entry count.
  localparam int DIM  = 3;
  localparam int NENT = DIM * DIM;

  // Cyclic neighbors of a row/column index, used for the 2x2 cofactors.
  function automatic int nx1(input int k);
    return (k == DIM - 1) ? 0 : k + 1;
  endfunction

  function automatic int nx2(input int k);
    return (k == 0) ? DIM - 1 : k - 1;
  endfunction

endpackage

@@ src/mi3_front.sv @@
// mi3_front: cofactors, determinant and magnitudes, four register stages.
// Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_front #(
  parameter int W = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic signed [W-1:0] a_i [mi3_pkg::NENT],
  output logic                valid_o,
  output logic [2*W:0]        cmag_o [mi3_pkg::NENT],
  output logic                neg_o [mi3_pkg::NENT],
  output logic [3*W+2:0]      dmag_o,
  output logic                sing_o
);
  import mi3_pkg::*;

  localparam int CW = 2 * W + 1;   // cofactor
  localparam int PW = W + CW;      // det partial product
  localparam int DW = 3 * W + 3;   // determinant

  logic [3:0] v_q;

  logic signed [CW-1:0] cof_d  [NENT];
  logic signed [CW-1:0] cof1_q [NENT];
  logic signed [CW-1:0] cof2_q [NENT];
  logic signed [CW-1:0] cof3_q [NENT];
  logic signed [W-1:0]  row_q  [DIM];
  logic signed [PW-1:0] dp_d   [DIM];
  logic signed [PW-1:0] dp_q   [DIM];
  logic signed [DW-1:0] det_d;
  logic signed [DW-1:0] det_q;
  logic [CW-1:0]        cmag_q [NENT];
  logic                 neg_q  [NENT];
  logic [DW-1:0]        dmag_q;
  logic                 sing_q;

  // adjugate (i,j) = cofactor of A at (j,i)
  for (genvar i = 0; i < DIM; i++) begin : g_row
    for (genvar j = 0; j < DIM; j++) begin : g_col
      localparam int R1 = nx1(j);
      localparam int R2 = nx2(j);
      localparam int C1 = nx1(i);
      localparam int C2 = nx2(i);
      logic signed [2*W-1:0] p1, p2;
      assign p1 = a_i[R1*DIM+C1] * a_i[R2*DIM+C2];
      assign p2 = a_i[R1*DIM+C2] * a_i[R2*DIM+C1];
      assign cof_d[i*DIM+j] = CW'(p1) - CW'(p2);
    end
  end

  for (genvar i = 0; i < DIM; i++) begin : g_dp
    assign dp_d[i] = PW'(row_q[i]) * PW'(cof1_q[i*DIM]);
  end

  assign det_d = DW'(dp_q[0]) + DW'(dp_q[1]) + DW'(dp_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NENT; k++) begin
      cof1_q[k] <= cof_d[k];
      cof2_q[k] <= cof1_q[k];
      cof3_q[k] <= cof2_q[k];
      cmag_q[k] <= cof3_q[k][CW-1] ? CW'(-cof3_q[k]) : CW'(cof3_q[k]);
      neg_q[k]  <= cof3_q[k][CW-1] ^ det_q[DW-1];
    end
    for (int i = 0; i < DIM; i++) begin
      row_q[i] <= a_i[i];
      dp_q[i]  <= dp_d[i];
    end
    det_q  <= det_d;
    dmag_q <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
    sing_q <= (det_q == '0);
  end

  assign valid_o = v_q[3];
  assign cmag_o  = cmag_q;
  assign neg_o   = neg_q;
  assign dmag_o  = dmag_q;
  assign sing_o  = sing_q;

endmodule

@@ src/mi3_div.sv @@
// mi3_div: pipelined restoring divider, one quotient bit per stage,
// with round-half-away sign fixup and saturation. Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_div #(
  parameter int NW = 44,
  parameter int OW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [NW-1:0] den_i,
  input  logic          neg_i,
  input  logic          sing_i,
  output logic          valid_o,
  output logic [OW-1:0] res_o,
  output logic          sing_o
);
  import mi3_pkg::*;

  localparam int XW = NW + OW;
  localparam logic [OW-1:0] LIM  = {1'b1, {(OW-1){1'b0}}};
  localparam logic [OW-1:0] MAXP = ~LIM;

  logic [OW:0]    v_q;
  logic           vout_q;
  logic [NW-1:0]  rem_q [OW+1];
  logic [NW-1:0]  rem_d [OW+1];
  logic [OW-1:0]  quo_q [OW+1];
  logic [OW-1:0]  quo_d [OW+1];
  logic [NW-1:0]  den_q [OW+1];
  logic [OW:0]    neg_q, ovf_q, sing_q;
  logic           ovf_d;
  logic [OW-1:0]  res_d, res_q, q_fin;
  logic           sout_q;

  // quotient >= 2^OW means saturation regardless of the low bits
  assign ovf_d = {{OW{1'b0}}, num_i} >= {den_i, {OW{1'b0}}};

  assign rem_d[0] = num_i;
  assign quo_d[0] = '0;

  for (genvar s = 0; s < OW; s++) begin : g_stage
    localparam int B = OW - 1 - s;
    logic [XW-1:0] sh, diff;
    logic          ge;
    assign sh   = XW'(den_q[s]) << B;
    assign ge   = XW'(rem_q[s]) >= sh;
    assign diff = XW'(rem_q[s]) - sh;
    assign rem_d[s+1] = ge ? diff[NW-1:0] : rem_q[s];
    assign quo_d[s+1] = ge ? (quo_q[s] | (OW'(1) << B)) : quo_q[s];
  end

  assign q_fin = quo_q[OW];

  always_comb begin
    if (sing_q[OW]) begin
      res_d = '0;
    end else if (neg_q[OW]) begin
      res_d = (ovf_q[OW] || q_fin > LIM) ? LIM : (~q_fin + OW'(1));
    end else begin
      res_d = (ovf_q[OW] || q_fin >= LIM) ? MAXP : q_fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      vout_q <= 1'b0;
    end else begin
      v_q    <= {v_q[OW-1:0], valid_i};
      vout_q <= v_q[OW];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= rem_d[0];
    quo_q[0] <= quo_d[0];
    den_q[0] <= den_i;
    for (int s = 0; s < OW; s++) begin
      rem_q[s+1] <= rem_d[s+1];
      quo_q[s+1] <= quo_d[s+1];
      den_q[s+1] <= den_q[s];
    end
    neg_q  <= {neg_q[OW-1:0], neg_i};
    ovf_q  <= {ovf_q[OW-1:0], ovf_d};
    sing_q <= {sing_q[OW-1:0], sing_i};
    res_q  <= res_d;
    sout_q <= sing_q[OW];
  end

  assign valid_o = vout_q;
  assign res_o   = res_q;
  assign sing_o  = sout_q;

endmodule

@@ src/matrix3x3_inverse_top.sv @@
// matrix3x3_inverse_top: 3x3 matrix inverse by adjugate over determinant.
// Throughput: one matrix per cycle; busy stays low, the pipeline never stalls.
// The dividers retire one quotient bit per stage.
// Reset: rst_ni async active low clears all valid bits; data regs not reset.
// Depends on mi3_pkg, mi3_front, mi3_div.
`timescale 1ns / 1ps

module matrix3x3_inverse_top #(
  parameter int IN_WIDTH  = 16,
  parameter int OUT_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [IN_WIDTH-1:0]  a11_i,
  input  logic signed [IN_WIDTH-1:0]  a12_i,
  input  logic signed [IN_WIDTH-1:0]  a13_i,
  input  logic signed [IN_WIDTH-1:0]  a21_i,
  input  logic signed [IN_WIDTH-1:0]  a22_i,
  input  logic signed [IN_WIDTH-1:0]  a23_i,
  input  logic signed [IN_WIDTH-1:0]  a31_i,
  input  logic signed [IN_WIDTH-1:0]  a32_i,
  input  logic signed [IN_WIDTH-1:0]  a33_i,
  output logic                        done_o,
  output logic signed [OUT_WIDTH-1:0] b11_o,
  output logic signed [OUT_WIDTH-1:0] b12_o,
  output logic signed [OUT_WIDTH-1:0] b13_o,
  output logic signed [OUT_WIDTH-1:0] b21_o,
  output logic signed [OUT_WIDTH-1:0] b22_o,
  output logic signed [OUT_WIDTH-1:0] b23_o,
  output logic signed [OUT_WIDTH-1:0] b31_o,
  output logic signed [OUT_WIDTH-1:0] b32_o,
  output logic signed [OUT_WIDTH-1:0] b33_o,
  output logic                        singular_o
);
  import mi3_pkg::*;

  // Widths: cofactor 2W+1, determinant 3W+3. The divider word holds
  // 2|C|*2^24 + |D| and 2|D|, whichever is wider, plus one bit.
  localparam int CW  = 2 * IN_WIDTH + 1;
  localparam int DW  = 3 * IN_WIDTH + 3;
  localparam int NA  = CW + FRAC_SHIFT + 1;
  localparam int NW  = ((NA > DW) ? NA : DW) + 1;
  localparam int LAT = OUT_WIDTH + 7;

  logic signed [IN_WIDTH-1:0] mat [NENT];
  logic                       fr_valid;
  logic [CW-1:0]              fr_cmag [NENT];
  logic                       fr_neg  [NENT];
  logic [DW-1:0]              fr_dmag;
  logic                       fr_sing;

  // Stage 5: numerator / denominator of the rounded quotient
  // q = floor((2|C|*2^24 + |D|) / (2|D|))
  logic                       s5_v_q;
  logic [NW-1:0]              num_q [NENT];
  logic [NW-1:0]              den_q;
  logic                       neg_q [NENT];
  logic                       sing_q;

  logic [NENT-1:0]            dv_valid;
  logic [NENT-1:0]            dv_sing;
  logic [OUT_WIDTH-1:0]       dv_res [NENT];

  assign busy = 1'b0;

  assign mat[0] = a11_i;
  assign mat[1] = a12_i;
  assign mat[2] = a13_i;
  assign mat[3] = a21_i;
  assign mat[4] = a22_i;
  assign mat[5] = a23_i;
  assign mat[6] = a31_i;
  assign mat[7] = a32_i;
  assign mat[8] = a33_i;

  mi3_front #(
    .W (IN_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .a_i     (mat),
    .valid_o (fr_valid),
    .cmag_o  (fr_cmag),
    .neg_o   (fr_neg),
    .dmag_o  (fr_dmag),
    .sing_o  (fr_sing)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else begin
      s5_v_q <= fr_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NENT; k++) begin
      num_q[k] <= NW'({fr_cmag[k], {(FRAC_SHIFT+1){1'b0}}}) + NW'(fr_dmag);
      neg_q[k] <= fr_neg[k];
    end
    den_q  <= NW'({fr_dmag, 1'b0});
    sing_q <= fr_sing;
  end

  // Nine dividers in lockstep, one per inverse entry.
  for (genvar k = 0; k < NENT; k++) begin : g_div
    mi3_div #(
      .NW (NW),
      .OW (OUT_WIDTH)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (s5_v_q),
      .num_i   (num_q[k]),
      .den_i   (den_q),
      .neg_i   (neg_q[k]),
      .sing_i  (sing_q),
      .valid_o (dv_valid[k]),
      .res_o   (dv_res[k]),
      .sing_o  (dv_sing[k])
    );
  end

  assign done_o     = dv_valid[0];
  assign singular_o = dv_sing[0];
  assign b11_o = dv_res[0];
  assign b12_o = dv_res[1];
  assign b13_o = dv_res[2];
  assign b21_o = dv_res[3];
  assign b22_o = dv_res[4];
  assign b23_o = dv_res[5];
  assign b31_o = dv_res[6];
  assign b32_o = dv_res[7];
  assign b33_o = dv_res[8];

`ifndef ASSERT_OFF
  // every transfer in comes out as a result on done_o
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LAT done_o)
    else $error("result missing after fixed latency");

  // the nine divider lanes stay in lockstep
  a_lockstep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_valid == '0) || (dv_valid == '1))
    else $error("divider lanes out of step");

  // singular result carries all-zero entries
  a_sing_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && singular_o) |-> (b11_o == '0 && b22_o == '0 && b33_o == '0
      && b12_o == '0 && b21_o == '0 && b13_o == '0 && b31_o == '0
      && b23_o == '0 && b32_o == '0))
    else $error("singular result with nonzero entry");
`endif

endmodule

@@ tb/tb_matrix3x3_inverse_top.sv @@
// tb_matrix3x3_inverse_top: self-checking bench for the 3x3 matrix inverse.
// Directed table then random matrices, checked against an adjugate predictor.
// Depends on mi3_pkg and matrix3x3_inverse_top.
`timescale 1ns / 1ps

module tb_matrix3x3_inverse_top;
  import mi3_pkg::*;

  localparam int IW = 16;
  localparam int OW = 32;
  localparam int LATENCY = OW + 7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_RANDOM = 830;

  // Matrix kinds used by the random generator.
  typedef enum int {MK_FULL, MK_SMALL, MK_SINGULAR, MK_DIAG, MK_EXTREME} mat_kind_e;

  typedef logic signed [IW-1:0] ent_t;
  typedef logic signed [OW-1:0] res_t;

  typedef struct {
    ent_t a [NENT];
  } matrix_t;

  typedef struct {
    res_t b [NENT];
    logic sing;
  } inverse_t;

  logic clk_i, rst_ni, start;
  logic busy, done_o, singular_o;
  ent_t a_in [NENT];
  res_t b11_o, b12_o, b13_o, b21_o, b22_o, b23_o, b31_o, b32_o, b33_o;
  res_t b_out [NENT];

  assign b_out = '{b11_o, b12_o, b13_o, b21_o, b22_o, b23_o, b31_o, b32_o, b33_o};

  matrix3x3_inverse_top #(.IN_WIDTH(IW), .OUT_WIDTH(OW)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .a11_i(a_in[0]), .a12_i(a_in[1]), .a13_i(a_in[2]),
    .a21_i(a_in[3]), .a22_i(a_in[4]), .a23_i(a_in[5]),
    .a31_i(a_in[6]), .a32_i(a_in[7]), .a33_i(a_in[8]),
    .done_o(done_o),
    .b11_o(b11_o), .b12_o(b12_o), .b13_o(b13_o),
    .b21_o(b21_o), .b22_o(b22_o), .b23_o(b23_o),
    .b31_o(b31_o), .b32_o(b32_o), .b33_o(b33_o),
    .singular_o(singular_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Expected inverses, oldest first.
  inverse_t pending_inverses [$];
  int n_errors = 0;
  int idle_cycles = 0;
  int idle_pct = 0;       // sender idle percentage for the current phase
  bit hold_off = 1'b0;    // sender pauses while this is set

  // ---------------------------------------------------------------------------
  // Predictor: exact adjugate / determinant, round half away from zero, saturate.
  // Cofactors fit in 33 bits, det in 50; numerator C << 24 needs 57 bits.
  // ---------------------------------------------------------------------------
  function automatic res_t div_round_sat(input logic signed [127:0] num,
                                         input logic signed [127:0] den);
    logic [127:0] n, d, q;
    logic neg;
    logic [127:0] lim;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (2 * n + d) / (2 * d);
    lim = 128'd1 << (OW - 1);
    if (neg) begin
      if (q > lim) q = lim;
      return res_t'(-q);
    end
    if (q >= lim) q = lim - 1;
    return res_t'(q);
  endfunction

  function automatic inverse_t invert_matrix(input matrix_t m);
    logic signed [127:0] e [DIM][DIM];
    logic signed [127:0] adj [DIM][DIM];
    logic signed [127:0] det;
    inverse_t r;
    for (int i = 0; i < DIM; i++)
      for (int j = 0; j < DIM; j++)
        e[i][j] = m.a[i * DIM + j];
    // Adjugate entry (i,j) is the cofactor at (j,i): rows from j, columns from i.
    for (int i = 0; i < DIM; i++)
      for (int j = 0; j < DIM; j++) begin
        int r1, r2, c1, c2;
        r1 = (j + 1) % DIM; r2 = (j + 2) % DIM;
        c1 = (i + 1) % DIM; c2 = (i + 2) % DIM;
        adj[i][j] = e[r1][c1] * e[r2][c2] - e[r1][c2] * e[r2][c1];
      end
    det = 0;
    for (int i = 0; i < DIM; i++) det += e[0][i] * adj[i][0];
    r.sing = (det == 0);
    for (int k = 0; k < NENT; k++)
      r.b[k] = r.sing ? '0
             : div_round_sat(adj[k / DIM][k % DIM] <<< FRAC_SHIFT, det);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: done_o is a one-cycle strobe, sampled at the edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_inverses.size() == 0) begin
        $error("result with no matrix outstanding");
        n_errors++;
      end else begin
        inverse_t x;
        x = pending_inverses.pop_front();
        for (int k = 0; k < NENT; k++)
          if (b_out[k] !== x.b[k]) begin
            $error("b%0d%0d: expected %0d, got %0d", k / DIM + 1, k % DIM + 1,
                   x.b[k], b_out[k]);
            n_errors++;
          end
        if (singular_o !== x.sing) begin
          $error("singular: expected %0b, got %0b", x.sing, singular_o);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Drives one matrix; start is lowered only on idle cycles, so back-to-back
  // transfers keep start high without a second assignment in the same step.
  task automatic send_matrix(input matrix_t m);
    while (hold_off || ($urandom_range(99) < idle_pct)) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    a_in <= m.a;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_inverses.push_back(invert_matrix(m));
  endtask

  function automatic ent_t rand_ent(input mat_kind_e kind);
    case (kind)
      MK_SMALL:   return ent_t'($urandom_range(1024) - 512);
      MK_EXTREME: begin
        case ($urandom_range(3))
          0: return ent_t'(16'h8000);
          1: return ent_t'(16'h7fff);
          2: return ent_t'(0);
          default: return ent_t'($urandom);
        endcase
      end
      default:    return ent_t'($urandom);
    endcase
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    mat_kind_e kind;
    kind = mat_kind_e'($urandom_range(MK_EXTREME));
    foreach (m.a[k]) m.a[k] = rand_ent(kind);
    if (kind == MK_DIAG) begin
      foreach (m.a[k]) if (k % (DIM + 1) != 0) m.a[k] = '0;
    end else if (kind == MK_SINGULAR) begin
      // Duplicate or zero a whole row so det is exactly zero.
      int src, dst;
      bit dup;
      src = $urandom_range(DIM - 1);
      dst = (src + 1 + $urandom_range(1)) % DIM;
      dup = $urandom_range(1);
      for (int c = 0; c < DIM; c++)
        m.a[dst * DIM + c] = dup ? m.a[src * DIM + c] : ent_t'(0);
    end
    return m;
  endfunction

  // Directed rows. Fixed expectations only where they are obvious.
  typedef struct {
    matrix_t m;
    bit has_fixed;
    inverse_t fixed;
  } vector_t;

  function automatic vector_t mk_vec(input int unsigned d0, d1, d2, d3, d4, d5,
                                     d6, d7, d8);
    vector_t v;
    v.m.a = '{ent_t'(d0), ent_t'(d1), ent_t'(d2), ent_t'(d3), ent_t'(d4),
              ent_t'(d5), ent_t'(d6), ent_t'(d7), ent_t'(d8)};
    v.has_fixed = 1'b0;
    return v;
  endfunction

  vector_t directed_table [$];

  initial begin
    vector_t v;
    matrix_t z;
    rst_ni = 1'b0;
    start = 1'b0;
    foreach (a_in[k]) a_in[k] = '0;

    // All zeros: singular, entries cleared.
    v = mk_vec(0, 0, 0, 0, 0, 0, 0, 0, 0);
    v.has_fixed = 1'b1; v.fixed.sing = 1'b1; foreach (v.fixed.b[k]) v.fixed.b[k] = '0;
    directed_table.push_back(v);
    // Identity (1.0 = 0x100): inverse is identity, 1.0 = 0x10000.
    v = mk_vec('h100, 0, 0, 0, 'h100, 0, 0, 0, 'h100);
    v.has_fixed = 1'b1; v.fixed.sing = 1'b0;
    foreach (v.fixed.b[k]) v.fixed.b[k] = (k % 4 == 0) ? res_t'(32'h10000) : '0;
    directed_table.push_back(v);
    // Tiny diagonal (LSB = 1/256): inverse diagonal is 256.0 = 0x1000000.
    v = mk_vec(1, 0, 0, 0, 1, 0, 0, 0, 1);
    v.has_fixed = 1'b1; v.fixed.sing = 1'b0;
    foreach (v.fixed.b[k]) v.fixed.b[k] = (k % 4 == 0) ? res_t'(32'h01000000) : '0;
    directed_table.push_back(v);
    // Negative tiny diagonal: inverse diagonal is -256.0.
    v = mk_vec('hffff, 0, 0, 0, 'hffff, 0, 0, 0, 'hffff);
    v.has_fixed = 1'b1; v.fixed.sing = 1'b0;
    foreach (v.fixed.b[k]) v.fixed.b[k] = (k % 4 == 0) ? res_t'(32'hff000000) : '0;
    directed_table.push_back(v);
    // All entries equal: singular.
    v = mk_vec('h7fff, 'h7fff, 'h7fff, 'h7fff, 'h7fff, 'h7fff, 'h7fff, 'h7fff, 'h7fff);
    v.has_fixed = 1'b1; v.fixed.sing = 1'b1; foreach (v.fixed.b[k]) v.fixed.b[k] = '0;
    directed_table.push_back(v);
    // Extremes and mixed cases, predictor-checked.
    directed_table.push_back(mk_vec('h8000, 0, 0, 0, 'h8000, 0, 0, 0, 'h8000));
    directed_table.push_back(mk_vec('h7fff, 0, 0, 0, 'h7fff, 0, 0, 0, 'h7fff));
    directed_table.push_back(mk_vec('h8000, 'h7fff, 'h8000, 'h7fff, 'h8000,
                                    'h7fff, 'h8000, 'h8000, 'h7fff));
    directed_table.push_back(mk_vec('h8000, 'h7fff, 0, 0, 'h8000, 'h7fff,
                                    'h7fff, 0, 'h8000));
    directed_table.push_back(mk_vec(0, 'h100, 0, 0, 0, 'h100, 'h100, 0, 0));
    directed_table.push_back(mk_vec('h200, 'h100, 0, 'h100, 'h200, 'h100, 0, 'h100, 'h200));
    // Entries of 3 and -3 raw units: rounding ties and fractions.
    directed_table.push_back(mk_vec(3, 0, 0, 0, 'h300, 0, 0, 0, 'h300));
    directed_table.push_back(mk_vec('hfffd, 1, 0, 1, 'h200, 0, 0, 0, 'h100));
    directed_table.push_back(mk_vec('h5555, 'haaaa, 'h1234, 'hedcb, 'h0f0f,
                                    'hf0f0, 'h3c3c, 'hc3c3, 'h0001));
    // Second row zero: singular with nonzero elsewhere.
    directed_table.push_back(mk_vec('h123, 'h456, 'h789, 0, 0, 0, 'hfedc, 'hba9, 'h876));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling.
    idle_pct = 0;
    foreach (directed_table[i]) begin
      send_matrix(directed_table[i].m);
      if (directed_table[i].has_fixed) begin
        // Fixed expectation must agree with the predictor; use it as the check.
        inverse_t p;
        bit differs;
        p = pending_inverses.pop_back();
        differs = (p.sing !== directed_table[i].fixed.sing);
        for (int k = 0; k < NENT; k++)
          if (p.b[k] !== directed_table[i].fixed.b[k]) differs = 1'b1;
        if (differs) begin
          $error("directed row %0d: predictor disagrees with table", i);
          n_errors++;
        end
        pending_inverses.push_back(directed_table[i].fixed);
      end
    end

    // Pause until all outstanding inverses have come back.
    hold_off = 1'b1;
    start <= 1'b0;
    while (pending_inverses.size() != 0) @(posedge clk_i);
    hold_off = 1'b0;

    // Random phases: no idling, sender idle 71%, a receiver phase (no effect,
    // receiver cannot stall), then 13%.
    for (int i = 0; i < N_RANDOM; i++) begin
      case (i * 4 / N_RANDOM)
        0: idle_pct = 0;
        1: idle_pct = 71;
        2: idle_pct = 0;
        default: idle_pct = 13;
      endcase
      // Short no-idle bursts inside idle phases.
      if ((i % 50) < 8) idle_pct = 0;
      z = rand_matrix();
      send_matrix(z);
    end
    start <= 1'b0;

    while (pending_inverses.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/mi3_pkg.sv
src/mi3_front.sv
src/mi3_div.sv
src/matrix3x3_inverse_top.sv
tb/tb_matrix3x3_inverse_top.sv
